[rtl/assert_macros.svh]
// Assertion macros shared by the pose integrator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that a condition holds in the cycle after another.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/hpi_pkg.sv]
// Package with constants, types and functions of the pose integrator.
package hpi_pkg;

    localparam int CordicSteps = 16;
    localparam int CordicIdxW  = 5;
    localparam logic signed [33:0] CordicGain = 34'sd652032874;

    localparam logic [1:0] RegStepTime = 2'd0;
    localparam logic [1:0] RegPivotX   = 2'd1;
    localparam logic [1:0] RegPivotY   = 2'd2;

    // Arctangent of 2^-i as a 32-bit binary angle.
    function automatic logic signed [33:0] atan_lut(input logic [CordicIdxW-1:0] i);
        logic signed [33:0] r;
        case (i)
            5'd0:  r = 34'sd536870912;
            5'd1:  r = 34'sd316933406;
            5'd2:  r = 34'sd167458907;
            5'd3:  r = 34'sd85004756;
            5'd4:  r = 34'sd42667331;
            5'd5:  r = 34'sd21354465;
            5'd6:  r = 34'sd10679838;
            5'd7:  r = 34'sd5340245;
            5'd8:  r = 34'sd2670163;
            5'd9:  r = 34'sd1335087;
            5'd10: r = 34'sd667544;
            5'd11: r = 34'sd333772;
            5'd12: r = 34'sd166886;
            5'd13: r = 34'sd83443;
            5'd14: r = 34'sd41722;
            5'd15: r = 34'sd20861;
            5'd16: r = 34'sd10430;
            5'd17: r = 34'sd5215;
            5'd18: r = 34'sd2608;
            5'd19: r = 34'sd1304;
            5'd20: r = 34'sd652;
            5'd21: r = 34'sd326;
            5'd22: r = 34'sd163;
            5'd23: r = 34'sd81;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

    // One rotation vector carried down the CORDIC row.
    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic               flip;
    } rot_t;

    // Item payload carried alongside the CORDIC row.
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] heading_new;
        logic signed [39:0] dx;
        logic signed [39:0] dy;
    } item_t;

endpackage

[rtl/hpi_cordic_cell.sv]
// One CORDIC rotation cell: a fixed-shift micro-rotation and a register for each of two vectors.
module hpi_cordic_cell
    import hpi_pkg::*;
(
    input  logic                  clk,
    input  logic [CordicIdxW-1:0] stage,
    input  rot_t                  a_in,
    input  rot_t                  b_in,
    output rot_t                  a_out,
    output rot_t                  b_out
);

    function automatic rot_t step(input rot_t r);
        rot_t o;
        logic signed [33:0] xs;
        logic signed [33:0] ys;
        xs = r.x >>> stage;
        ys = r.y >>> stage;
        o = r;
        if (!r.z[33]) begin
            o.x = r.x - ys;
            o.y = r.y + xs;
            o.z = r.z - atan_lut(stage);
        end else begin
            o.x = r.x + ys;
            o.y = r.y - xs;
            o.z = r.z + atan_lut(stage);
        end
        return o;
    endfunction

    rot_t a_reg;
    rot_t b_reg;

    // Advance both angles one micro-rotation.
    always_ff @(posedge clk)
    begin
        a_reg <= step(a_in);
        b_reg <= step(b_in);
    end

    assign a_out = a_reg;
    assign b_out = b_reg;

endmodule

[rtl/holonomic_pose_integrator.sv]
// Holonomic pose integrator: pipelined CORDIC row plus pivot and displacement math.
// From start to done an item passes stages 1 and 2, a row of 16 CORDIC cells and stages A to D.
// Throughput: one transaction per cycle; busy is always low, items enter each cycle.
// The CORDIC cell row sets the depth; each cell is one micro-rotation.
// Reset clears the valid pipe and loads step_time 167772 and zero pivot offsets.
// The receiver cannot stall: done pulses for one cycle with the result.
module holonomic_pose_integrator
    import hpi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [15:0] heading,
    input  logic signed [23:0] vel_forward,
    input  logic signed [23:0] vel_lateral,
    input  logic signed [23:0] turn_rate,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    output logic               done,
    output logic signed [31:0] next_x,
    output logic signed [31:0] next_y,
    output logic signed [15:0] next_heading
);

`include "assert_macros.svh"

    localparam int Depth = CordicSteps + 6;

    logic [23:0]        step_time_reg;
    logic signed [23:0] piv_x_reg;
    logic signed [23:0] piv_y_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Write configuration registers; ignore unknown indexes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            step_time_reg <= 24'd167772;
            piv_x_reg     <= '0;
            piv_y_reg     <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                RegStepTime: step_time_reg <= cfg_data;
                RegPivotX:   piv_x_reg     <= cfg_data;
                RegPivotY:   piv_y_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [Depth-1:0] vld_reg;

    // Advance the valid pipe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[Depth-2:0], start};
        end
    end

    // Stage 1: products with step time.
    logic signed [47:0] pfx_reg, pfy_reg, pw_reg;
    logic signed [31:0] s1_px_reg, s1_py_reg;
    logic signed [15:0] s1_h_reg;

    always_ff @(posedge clk)
    begin
        pfx_reg   <= vel_forward * $signed({1'b0, step_time_reg});
        pfy_reg   <= vel_lateral * $signed({1'b0, step_time_reg});
        pw_reg    <= turn_rate * $signed({1'b0, step_time_reg});
        s1_px_reg <= pos_x;
        s1_py_reg <= pos_y;
        s1_h_reg  <= heading;
    end

    // Stage 2: round products, form new heading and CORDIC start vectors.
    item_t s2_reg;
    logic signed [47:0] dxr, dyr, wr;
    logic signed [15:0] hn;

    always_comb
    begin
        dxr = (pfx_reg + 48'sd32768) >>> 16;
        dyr = (pfy_reg + 48'sd32768) >>> 16;
        wr  = (pw_reg + 48'sd8388608) >>> 24;
        hn  = s1_h_reg + wr[15:0];
    end

    function automatic rot_t rot_init(input logic signed [15:0] h);
        rot_t r;
        logic [31:0] a;
        a = {h, 16'd0};
        r.flip = 1'b0;
        if (a[31] != a[30]) begin
            a = a + 32'h8000_0000;
            r.flip = 1'b1;
        end
        r.x = CordicGain;
        r.y = '0;
        r.z = {{2{a[31]}}, a};
        return r;
    endfunction

    rot_t ra_reg, rb_reg;

    always_ff @(posedge clk)
    begin
        s2_reg.pos_x       <= s1_px_reg;
        s2_reg.pos_y       <= s1_py_reg;
        s2_reg.heading_new <= hn;
        s2_reg.dx          <= dxr[39:0];
        s2_reg.dy          <= dyr[39:0];
        ra_reg             <= rot_init(s1_h_reg);
        rb_reg             <= rot_init(hn);
    end

    // Row of CORDIC cells with the item carried alongside.
    rot_t  ca [CordicSteps+1];
    rot_t  cb [CordicSteps+1];
    item_t it_reg [CordicSteps];

    assign ca[0] = ra_reg;
    assign cb[0] = rb_reg;

    for (genvar g = 0; g < CordicSteps; g++) begin : g_cell
        hpi_cordic_cell u_cell (
            .clk   (clk),
            .stage (CordicIdxW'(g)),
            .a_in  (ca[g]),
            .b_in  (cb[g]),
            .a_out (ca[g+1]),
            .b_out (cb[g+1])
        );
        always_ff @(posedge clk)
        begin
            if (g == 0) it_reg[g] <= s2_reg;
            else        it_reg[g] <= it_reg[(g == 0) ? 0 : g-1];
        end
    end

    // Stage A: apply flips to get sine and cosine.
    logic signed [33:0] c1_reg, s1c_reg, c2_reg, s2c_reg;
    item_t ia_reg;
    rot_t  fa, fb;

    assign fa = ca[CordicSteps];
    assign fb = cb[CordicSteps];

    always_ff @(posedge clk)
    begin
        c1_reg  <= fa.flip ? -fa.x : fa.x;
        s1c_reg <= fa.flip ? -fa.y : fa.y;
        c2_reg  <= fb.flip ? -fb.x : fb.x;
        s2c_reg <= fb.flip ? -fb.y : fb.y;
        ia_reg  <= it_reg[CordicSteps-1];
    end

    // Stage B: all products, one multiplier deep.
    logic signed [57:0] m_oxc1, m_oys1, m_oxs1, m_oyc1;
    logic signed [57:0] m_oxc2, m_oys2, m_oxs2, m_oyc2;
    logic signed [73:0] m_dxc, m_dys, m_dxs, m_dyc;
    item_t ib_reg;

    always_ff @(posedge clk)
    begin
        m_oxc1 <= piv_x_reg * c1_reg;
        m_oys1 <= piv_y_reg * s1c_reg;
        m_oxs1 <= piv_x_reg * s1c_reg;
        m_oyc1 <= piv_y_reg * c1_reg;
        m_oxc2 <= piv_x_reg * c2_reg;
        m_oys2 <= piv_y_reg * s2c_reg;
        m_oxs2 <= piv_x_reg * s2c_reg;
        m_oyc2 <= piv_y_reg * c2_reg;
        m_dxc  <= ia_reg.dx * c1_reg;
        m_dys  <= ia_reg.dy * s1c_reg;
        m_dxs  <= ia_reg.dx * s1c_reg;
        m_dyc  <= ia_reg.dy * c1_reg;
        ib_reg <= ia_reg;
    end

    // Stage C: rounded terms.
    logic signed [35:0] t1x_reg, t1y_reg, t2x_reg, t2y_reg, tdx_reg, tdy_reg;
    logic signed [31:0] c_px_reg, c_py_reg;
    logic signed [15:0] c_h_reg;
    logic signed [58:0] a1x, a1y, a2x, a2y;
    logic signed [74:0] adx, ady;

    always_comb
    begin
        a1x = (59'(m_oxc1) - 59'(m_oys1) + 59'sd536870912) >>> 30;
        a1y = (59'(m_oxs1) + 59'(m_oyc1) + 59'sd536870912) >>> 30;
        a2x = (59'(m_oxc2) - 59'(m_oys2) + 59'sd536870912) >>> 30;
        a2y = (59'(m_oxs2) + 59'(m_oyc2) + 59'sd536870912) >>> 30;
        adx = (75'(m_dxc) - 75'(m_dys) + (75'sd1 <<< 37)) >>> 38;
        ady = (75'(m_dxs) + 75'(m_dyc) + (75'sd1 <<< 37)) >>> 38;
    end

    always_ff @(posedge clk)
    begin
        t1x_reg  <= a1x[35:0];
        t1y_reg  <= a1y[35:0];
        t2x_reg  <= a2x[35:0];
        t2y_reg  <= a2y[35:0];
        tdx_reg  <= adx[35:0];
        tdy_reg  <= ady[35:0];
        c_px_reg <= ib_reg.pos_x;
        c_py_reg <= ib_reg.pos_y;
        c_h_reg  <= ib_reg.heading_new;
    end

    // Stage D: sum, saturate and register the result.
    logic signed [38:0] sx, sy;
    logic signed [31:0] nx_reg, ny_reg;
    logic signed [15:0] nh_reg;

    function automatic logic signed [31:0] sat32(input logic signed [38:0] v);
        if (v > 39'sd2147483647)       return 32'sh7fffffff;
        else if (v < -39'sd2147483648) return 32'sh80000000;
        else                           return v[31:0];
    endfunction

    always_comb
    begin
        sx = 39'(c_px_reg) + 39'(t1x_reg) + 39'(tdx_reg) - 39'(t2x_reg);
        sy = 39'(c_py_reg) + 39'(t1y_reg) + 39'(tdy_reg) - 39'(t2y_reg);
    end

    always_ff @(posedge clk)
    begin
        nx_reg <= sat32(sx);
        ny_reg <= sat32(sy);
        nh_reg <= c_h_reg;
    end

    assign done         = vld_reg[Depth-1];
    assign next_x       = nx_reg;
    assign next_y       = ny_reg;
    assign next_heading = nh_reg;

    `ASSERT_NEXT(a_start_flows, clk, rst_n, start, vld_reg[0])
    `ASSERT_IMPLY(a_never_busy, clk, rst_n, 1'b1, !busy && cfg_ready)
    `ASSERT_NEXT(a_done_follows, clk, rst_n, vld_reg[Depth-2], done)

endmodule
